// File: rtl/crf_pkg.sv
// Shared types and codes for the coalescing record FIFO.
// Depends on nothing; crf_ctrl, crf_dpath and the top level import it.
package crf_pkg;

  // Operation code of an input beat (code 3 is unused and ignored)
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } crf_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_CLOSE_PEER = 2'd2,
    ST_EMPTY      = 2'd3
  } crf_status_t;

  // Input beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] key_system;
    logic [15:0] key_event;
    logic [31:0] revision;
    logic        is_transient;
    logic [31:0] payload;
  } crf_in_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [15:0] out_system;
    logic [15:0] out_event;
    logic [31:0] out_revision;
    logic        out_transient;
    logic [31:0] out_payload;
    logic [6:0]  occupancy;
  } crf_out_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_RD,
    S_SCAN,
    S_SHIFT,
    S_APPEND,
    S_FINISH
  } crf_state_t;

  // Which result the datapath stages
  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_FULL,
    RES_EMPTY,
    RES_POP
  } crf_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     latch;     // capture the input beat
    logic     rd_head;   // read the head slot, start a walk there
    logic     rd_next;   // read the slot after the walk pointer, advance it
    logic     mark_dst;  // move destination takes the walk pointer
    logic     wr_move;   // write read data into the move destination
    logic     unlink;    // one slot freed: tail back, count down
    logic     append;    // write new record at tail
    logic     pop;       // head forward, count down
    logic     clear;     // empty the queue
    crf_res_t res;       // result to stage
    logic     load_out;  // move staged result into the output register
  } crf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    crf_op_t op;         // operation of the latched beat
    logic    state_rec;  // both keys nonzero
    logic    empty;
    logic    full;
    logic    key_hit;    // slot under the walk has the same key pair
    logic    stale;      // that slot's revision is equal or newer
    logic    last_scan;  // slot under the walk is the last queued one
    logic    shift_end;  // slot after the walk pointer is the tail
    logic    out_free;   // output register can take a result now
  } crf_sts_t;

endpackage

// File: rtl/crf_stream_if.sv
// Valid/ready channel carrying one beat of type T.
// Depends on nothing; the top level uses it with the package beat types.
interface crf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/crf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module crf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/crf_ctrl.sv
// Controller of the coalescing record FIFO: sequences pop, clear, scan, shift
// and append. Depends on crf_pkg.
module crf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crf_pkg::crf_sts_t sts,
  output crf_pkg::crf_cmd_t cmd
);
  import crf_pkg::*;

  crf_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_PUSH: begin
            if (sts.state_rec && !sts.empty) begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_SCAN;
            end else begin
              state_nxt = S_APPEND;
            end
          end
          OP_POP: begin
            if (sts.empty) begin
              cmd.res   = RES_EMPTY;
              state_nxt = S_FINISH;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_POP_RD;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.res   = RES_OK;
            state_nxt = S_FINISH;
          end
          default: begin
            cmd.res   = RES_OK;
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_POP_RD: begin
        cmd.pop   = 1'b1;
        cmd.res   = RES_POP;
        state_nxt = S_FINISH;
      end
      // one queued slot compared per cycle, oldest first
      S_SCAN: begin
        if (sts.key_hit) begin
          if (sts.stale) begin
            cmd.res   = RES_OK;
            state_nxt = S_FINISH;
          end else if (sts.shift_end) begin
            cmd.unlink = 1'b1;
            state_nxt  = S_APPEND;
          end else begin
            cmd.mark_dst = 1'b1;
            cmd.rd_next  = 1'b1;
            state_nxt    = S_SHIFT;
          end
        end else if (sts.last_scan) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      // one slot moved forward per cycle until the tail
      S_SHIFT: begin
        cmd.wr_move = 1'b1;
        if (sts.shift_end) begin
          cmd.unlink = 1'b1;
          state_nxt  = S_APPEND;
        end else begin
          cmd.mark_dst = 1'b1;
          cmd.rd_next  = 1'b1;
        end
      end
      S_APPEND: begin
        if (sts.full) begin
          cmd.res = RES_FULL;
        end else begin
          cmd.append = 1'b1;
          cmd.res    = RES_OK;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

// File: rtl/crf_dpath.sv
// Datapath of the coalescing record FIFO: pointers, record RAM, walk
// pointer, result staging and output register. Depends on crf_pkg, crf_ram.
module crf_dpath #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  crf_pkg::crf_in_t  in_data,
  input  crf_pkg::crf_cmd_t cmd,
  output crf_pkg::crf_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output crf_pkg::crf_out_t out_data
);
  import crf_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = 65 + PAYLOAD_BITS;

  logic [AW-1:0] head_r, tail_r, ptr_r, dst_r;
  logic [CW-1:0] count_r, scan_left_r;
  crf_in_t       item_r;
  crf_out_t      res_r, res_nxt;
  crf_out_t      out_r, out_nxt;
  logic          out_vld_r;

  logic [RW-1:0] rdata, wdata;
  logic [AW-1:0] raddr, waddr, ptr_inc;
  logic          re, we;
  logic [31:0]   rd_key;
  logic [31:0]   rd_rev;
  logic          rd_trans;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  // Record layout: key pair, revision, transient flag, payload
  assign rd_key   = rdata[RW-1 -: 32];
  assign rd_rev   = rdata[RW-33 -: 32];
  assign rd_trans = rdata[PAYLOAD_BITS];
  assign rd_pay   = rdata[PAYLOAD_BITS-1:0];

  // RAM port steering
  assign ptr_inc = wrap_inc(ptr_r);
  assign re      = cmd.rd_head | cmd.rd_next;
  assign raddr   = cmd.rd_head ? head_r : ptr_inc;
  assign we      = cmd.wr_move | cmd.append;
  assign waddr   = cmd.wr_move ? dst_r : tail_r;
  assign wdata   = cmd.wr_move ? rdata
                 : {item_r.key_system, item_r.key_event, item_r.revision,
                    item_r.is_transient, PAYLOAD_BITS'(item_r.payload)};

  crf_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status toward the controller
  assign sts.op        = crf_op_t'(item_r.cmd);
  assign sts.state_rec = (item_r.key_system != '0) && (item_r.key_event != '0);
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == CW'(QUEUE_DEPTH));
  assign sts.key_hit   = (rd_key == {item_r.key_system, item_r.key_event});
  assign sts.stale     = (rd_rev >= item_r.revision);
  assign sts.last_scan = (scan_left_r == CW'(1));
  assign sts.shift_end = (ptr_inc == tail_r);
  assign sts.out_free  = !out_vld_r || out_ready;

  // Queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.clear) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.pop) begin
      head_r  <= wrap_inc(head_r);
      count_r <= count_r - 1'b1;
    end else if (cmd.unlink) begin
      tail_r  <= wrap_dec(tail_r);
      count_r <= count_r - 1'b1;
    end else if (cmd.append) begin
      tail_r  <= wrap_inc(tail_r);
      count_r <= count_r + 1'b1;
    end
  end

  // Walk pointer, move destination and input item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.rd_head) begin
      ptr_r       <= head_r;
      scan_left_r <= count_r;
    end else if (cmd.rd_next) begin
      ptr_r       <= ptr_inc;
      scan_left_r <= scan_left_r - 1'b1;
    end
    if (cmd.mark_dst) begin
      dst_r <= ptr_r;
    end
  end

  // Result staging
  always_comb begin
    res_nxt = res_r;
    case (cmd.res)
      RES_OK: begin
        res_nxt        = '0;
        res_nxt.status = ST_OK;
      end
      RES_FULL: begin
        res_nxt        = '0;
        res_nxt.status = item_r.is_transient ? ST_DROPPED : ST_CLOSE_PEER;
      end
      RES_EMPTY: begin
        res_nxt        = '0;
        res_nxt.status = ST_EMPTY;
      end
      RES_POP: begin
        res_nxt.status        = ST_OK;
        res_nxt.out_valid     = 1'b1;
        res_nxt.out_system    = rd_key[31:16];
        res_nxt.out_event     = rd_key[15:0];
        res_nxt.out_revision  = rd_rev;
        res_nxt.out_transient = rd_trans;
        res_nxt.out_payload   = 32'(rd_pay);
        res_nxt.occupancy     = '0;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Output register, occupancy taken after the operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_comb begin
    out_nxt           = res_r;
    out_nxt.occupancy = 7'(count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;
endmodule

// File: rtl/coalescing_record_fifo.sv
// Coalescing record FIFO, one item at a time. Clear, unused code and pop on empty stage
// their result at dispatch; pop of a record reads the head first; a push of a zero-key
// record or into an empty queue goes straight to append. A state push walks the record
// RAM (one write, one read port) one slot per cycle to scan and shift to the tail; a
// stale match ends the walk. A result waits while the output holds an untaken beat; the
// next item is accepted the cycle after the load. Reset zeroes head, tail and count.
module coalescing_record_fifo #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input logic         clk,
  input logic         rst_n,
  crf_stream_if.sink   in_if,
  crf_stream_if.source out_if
);
  import crf_pkg::*;

  crf_cmd_t cmd;
  crf_sts_t sts;

  crf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crf_dpath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_if.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_data  (out_if.data)
  );

  // A shift move and an append never share the write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_move && cmd.append))
    else $error("shift move and append in the same cycle");

  // An append never goes into a full queue
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.full)
    else $error("append into a full queue");

  // Only one item is in work at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second item accepted while one is in work");

  // A result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result overwrote an untaken beat");
endmodule
